// ===== sv/column_normalize_two_pass_macros.svh =====
// Assertion macros for the column normaliser
`ifndef COLUMN_NORMALIZE_TWO_PASS_MACROS_SVH
`define COLUMN_NORMALIZE_TWO_PASS_MACROS_SVH
// Check that a condition implies a consequence in the same cycle
`define CN_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Check that a condition implies a consequence in the next cycle
`define CN_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/cn_pkg.sv =====
// ----------------------------------------------------------------------------
// cn_pkg
// Shared types and constants of the column normaliser.
// ----------------------------------------------------------------------------
package cn_pkg;
    localparam int SAMPLE_W = 24;
    localparam int COL_W    = 12;
    localparam int SUMSQ_W  = 60;
    localparam int Q16_W    = 32;
    localparam logic [SUMSQ_W-1:0] SUMSQ_LIMIT = {SUMSQ_W{1'b1}};
    localparam logic signed [31:0] Q16_ONE  = 32'sd65536;
    localparam logic signed [31:0] Q16_MONE = -32'sd65536;

    typedef enum logic [0:0] { REQ_GATHER = 1'b0, REQ_APPLY = 1'b1 } req_t;
    typedef enum logic [0:0] { CFG_RANGE_LOW = 1'b0, CFG_RANGE_HIGH = 1'b1 } cfg_idx_t;
    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_ZERO = 2'd1, ST_SAT = 2'd2
    } status_t;
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EVAL, S_SQRT, S_DIV, S_OUT
    } fsm_t;

    typedef struct packed {
        logic                 start;
        logic [63:0]          radicand;
    } sqrt_req_t;
    typedef struct packed {
        logic                 done;
        logic [31:0]          root;
    } sqrt_rsp_t;
    typedef struct packed {
        logic                 start;
        logic signed [63:0]   num;
        logic signed [63:0]   den;
    } div_req_t;
    typedef struct packed {
        logic                 done;
        logic signed [63:0]   quot;
    } div_rsp_t;
endpackage

// ===== sv/cn_if.sv =====
// ----------------------------------------------------------------------------
// cn_in_if / cn_out_if / cn_cfg_if
// Valid-ready channels of the column normaliser.
// ----------------------------------------------------------------------------
interface cn_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [11:0] col_index;
    logic        first_row;
    logic signed [23:0] sample;
    modport source (output valid, req_type, col_index, first_row, sample, input ready);
    modport sink   (input valid, req_type, col_index, first_row, sample, output ready);
endinterface

interface cn_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] scaled_value;
    logic [1:0]  status;
    modport source (output valid, scaled_value, status, input ready);
    modport sink   (input valid, scaled_value, status, output ready);
endinterface

interface cn_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/cn_ram.sv =====
// ----------------------------------------------------------------------------
// cn_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== sv/cn_sqrt.sv =====
// ----------------------------------------------------------------------------
// cn_sqrt
// Integer square root, one result bit per cycle (32 steps, then done).
// ----------------------------------------------------------------------------
module cn_sqrt
    import cn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);
    logic [63:0] rad_reg;
    logic [65:0] part_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [65:0] trial;
    logic [65:0] acc;

    // Shift in two radicand bits, try root*4+1
    assign acc   = {part_reg[63:0], rad_reg[63:62]};
    assign trial = {32'd0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= req.radicand;
            part_reg <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[61:0], 2'b00};
            if (acc >= trial)
            begin
                part_reg <= acc - trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                part_reg <= acc;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    // Root as it stands after the final step
    assign rsp.root = root_reg;
endmodule

// ===== sv/cn_div.sv =====
// ----------------------------------------------------------------------------
// cn_div
// Signed restoring divider, truncating toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module cn_div
    import cn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [63:0] quo_reg;
    logic [63:0] rem_reg;
    logic [63:0] den_reg;
    logic        neg_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [64:0] sh;
    logic [63:0] an;
    logic [63:0] ad;

    assign an = req.num[63] ? (64'd0 - req.num) : req.num;
    assign ad = req.den[63] ? (64'd0 - req.den) : req.den;
    assign sh = {rem_reg, quo_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= an;
            rem_reg <= '0;
            den_reg <= ad;
            neg_reg <= req.num[63] ^ req.den[63];
        end
        else if (busy_reg)
        begin
            if (sh >= {1'b0, den_reg})
            begin
                rem_reg <= 64'(sh - {1'b0, den_reg});
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= sh[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = neg_reg ? (64'sd0 - $signed(quo_reg)) : $signed(quo_reg);
endmodule

// ===== sv/column_normalize_two_pass.sv =====
// ----------------------------------------------------------------------------
// column_normalize_two_pass
// Two-pass column normaliser: min-max scaling or L2 column normalisation.
// ----------------------------------------------------------------------------
// The matrix is streamed twice, row-major, one element per transaction. A
// gather transaction (req_type 0) reads the column's minimum, maximum and sum
// of squares from three RAMs, updates them and writes them back; it passes
// through the READ and EVAL states before the next transaction can be taken,
// and it gives no result. An apply transaction (req_type 1) yields one Q16.16
// result: with range -1.0..1.0 the sample is divided by the integer square
// root of the column's sum of squares (bit-serial root), else range_low +
// span*(x-min)/(max-min). The bit-serial divider sets the apply cost: L2 mode
// runs the root and then the divider, min-max mode runs only the divider, and
// a zero divisor skips the divider. A waiting result does not block the
// input; a second result holds in the output state until the first is taken.
// One transaction is in flight at a time, so no read-modify-write hazard
// arises. Reading a column never gathered since reset gives undefined results.
// Configuration is taken at any time and must only change while idle.
// ----------------------------------------------------------------------------
`include "column_normalize_two_pass_macros.svh"

module column_normalize_two_pass
    import cn_pkg::*;
#(
    parameter int MAX_COLS = 4096
) (
    input  logic   clk,
    input  logic   rst_n,
    cn_in_if.sink  in_ch,
    cn_out_if.source out_ch,
    cn_cfg_if.sink cfg
);
    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    fsm_t state_reg, state_next;
    logic signed [31:0] low_reg, high_reg;
    logic req_reg, first_reg;
    logic [AW-1:0] col_reg;
    logic signed [23:0] x_reg;
    logic signed [31:0] res_reg, res_next;
    logic [1:0] st_reg, st_next;
    logic out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic [1:0] out_status_reg;
    logic out_load;

    logic we;
    logic [AW-1:0] addr;
    logic [23:0] min_wd, max_wd, min_rd, max_rd;
    logic [59:0] sq_wd, sq_rd;

    sqrt_req_t sq_req;
    sqrt_rsp_t sq_rsp;
    div_req_t  dv_req;
    div_rsp_t  dv_rsp;

    logic l2_mode;
    logic [47:0] sq;
    logic [60:0] sum;
    logic signed [24:0] den_w;
    logic signed [32:0] span_w;
    logic signed [24:0] diff_w;
    logic signed [63:0] r_w;

    assign cfg.ready = 1'b1;
    assign in_ch.ready = (state_reg == S_IDLE);

    // Hand the result over once the output register is free
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= Q16_MONE;
            high_reg <= Q16_ONE;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_RANGE_LOW)
            begin
                low_reg <= cfg.data;
            end
            else
            begin
                high_reg <= cfg.data;
            end
        end
    end

    // Hold the accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            req_reg   <= in_ch.req_type;
            col_reg   <= AW'(in_ch.col_index % MAX_COLS);
            first_reg <= in_ch.first_row;
            x_reg     <= in_ch.sample;
        end
    end

    assign addr = col_reg;

    cn_ram #(.WIDTH(24), .DEPTH(MAX_COLS)) u_min (
        .clk(clk), .we(we), .addr(addr), .wdata(min_wd), .rdata(min_rd));
    cn_ram #(.WIDTH(24), .DEPTH(MAX_COLS)) u_max (
        .clk(clk), .we(we), .addr(addr), .wdata(max_wd), .rdata(max_rd));
    cn_ram #(.WIDTH(60), .DEPTH(MAX_COLS)) u_sq (
        .clk(clk), .we(we), .addr(addr), .wdata(sq_wd), .rdata(sq_rd));

    cn_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));
    cn_div  u_div  (.clk(clk), .rst_n(rst_n), .req(dv_req), .rsp(dv_rsp));

    // Gather update: seed on the first row, else fold in and saturate
    assign sq  = 48'(x_reg) * 48'(x_reg);
    assign sum = first_reg ? {13'd0, sq} : ({1'b0, sq_rd} + {13'd0, sq});
    assign min_wd = (first_reg || ($signed(x_reg) < $signed(min_rd))) ? x_reg : min_rd;
    assign max_wd = (first_reg || ($signed(x_reg) > $signed(max_rd))) ? x_reg : max_rd;
    assign sq_wd  = sum[60] ? SUMSQ_LIMIT : sum[59:0];

    assign l2_mode = (low_reg == Q16_MONE) && (high_reg == Q16_ONE);
    assign den_w   = 25'($signed(max_rd)) - 25'($signed(min_rd));
    assign diff_w  = 25'($signed(x_reg)) - 25'($signed(min_rd));
    assign span_w  = 33'($signed(high_reg)) - 33'($signed(low_reg));
    assign r_w     = l2_mode ? dv_rsp.quot : (dv_rsp.quot + 64'($signed(low_reg)));

    always_comb
    begin
        state_next = state_reg;
        we = 1'b0;
        sq_req = '0;
        dv_req = '0;
        res_next = res_reg;
        st_next = st_reg;
        sq_req.radicand = {4'd0, sq_rd};
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (req_reg == REQ_GATHER)
                begin
                    we = 1'b1;
                    state_next = S_IDLE;
                end
                else if (l2_mode)
                begin
                    sq_req.start = 1'b1;
                    state_next = S_SQRT;
                end
                else if (den_w == 25'sd0)
                begin
                    res_next = '0;
                    st_next = ST_ZERO;
                    state_next = S_OUT;
                end
                else
                begin
                    // span * diff fits 58 bits; one multiply into the divider
                    dv_req.start = 1'b1;
                    dv_req.num = 64'(span_w) * 64'(diff_w);
                    dv_req.den = 64'(den_w);
                    state_next = S_DIV;
                end
            end
            S_SQRT:
            begin
                if (sq_rsp.done)
                begin
                    if ((sq_rsp.root[30:0] == 31'd0) && !sq_rsp.root[31])
                    begin
                        res_next = '0;
                        st_next = ST_ZERO;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        dv_req.start = 1'b1;
                        dv_req.num = {{24{x_reg[23]}}, x_reg, 16'd0};
                        dv_req.den = {32'd0, sq_rsp.root};
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (dv_rsp.done)
                begin
                    if (r_w > 64'sd2147483647)
                    begin
                        res_next = 32'h7fffffff;
                        st_next = ST_SAT;
                    end
                    else if (r_w < -64'sd2147483648)
                    begin
                        res_next = 32'h80000000;
                        st_next = ST_SAT;
                    end
                    else
                    begin
                        res_next = r_w[31:0];
                        st_next = ST_OK;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Hold while the previous result still waits
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        st_reg  <= st_next;
        if (out_load)
        begin
            out_value_reg  <= res_reg;
            out_status_reg <= st_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.scaled_value = out_value_reg;
    assign out_ch.status       = out_status_reg;

    `CN_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, state_reg == S_IDLE, "ready outside idle")
    `CN_ASSERT_IMP(a_we_gather, clk, rst_n, we, req_reg == REQ_GATHER, "write on apply")
    `CN_ASSERT_NEXT(a_out_after, clk, rst_n, state_reg == S_OUT, out_ch.valid, "result lost")
    `CN_ASSERT_IMP(a_zero_st, clk, rst_n, out_ch.valid && out_ch.status == ST_ZERO, out_ch.scaled_value == 32'd0, "zero status with value")
endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the two-pass column normaliser.
// ----------------------------------------------------------------------------
// Matrices are gathered and then applied over valid-ready channels. A
// behavioural scaler predicts each result from its own copy of the column
// statistics and range registers, and results are compared in order.
// ----------------------------------------------------------------------------
module tb_top;
    import cn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] value;
        status_t            status;
    } scaled_t;

    logic clk;
    logic rst_n;

    cn_in_if  in_if();
    cn_out_if out_if();
    cn_cfg_if cfg_if();

    column_normalize_two_pass u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if),
        .cfg    (cfg_if)
    );

    // Shadow copy of the block's state
    logic signed [23:0] col_min [4096];
    logic signed [23:0] col_max [4096];
    longint unsigned    col_sumsq [4096];
    bit                 col_seeded [4096];
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;

    scaled_t scaled_q[$];
    int      error_count;
    int      items_sent;
    int      hold_off;      // receiver hold-off request, in cycles
    bit      no_idle;       // burst stretch: neither side idles

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #12ms;
        $display("[column_normalize_two_pass] ERROR");
        $finish;
    end

    // Integer square root, rounding down
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    -= root + bitv;
                root  = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Update the statistics or queue the expected scaled element
    function automatic void predict_scaling(req_t req, logic [11:0] col, logic first,
                                            logic signed [23:0] sample);
        longint          x;
        longint unsigned sq;
        longint unsigned lim;
        longint          r;
        longint          den;
        longint          norm;
        scaled_t         res;
        x   = sample;
        sq  = longint'(x * x);
        lim = {4'd0, SUMSQ_LIMIT};
        if (req == REQ_GATHER)
        begin
            if (first)
            begin
                col_min[col]    = sample;
                col_max[col]    = sample;
                col_sumsq[col]  = (sq > lim) ? lim : sq;
                col_seeded[col] = 1'b1;
            end
            else
            begin
                if (sample < col_min[col])
                    col_min[col] = sample;
                if (sample > col_max[col])
                    col_max[col] = sample;
                if (sq > lim || col_sumsq[col] > lim - sq)
                    col_sumsq[col] = lim;
                else
                    col_sumsq[col] += sq;
            end
            return;
        end
        r          = 0;
        res.status = ST_OK;
        if (range_low == Q16_MONE && range_high == Q16_ONE)
        begin
            norm = longint'(int_sqrt(col_sumsq[col]));
            if (norm == 0)
                res.status = ST_ZERO;
            else
                r = (x * 65536) / norm;
        end
        else
        begin
            den = longint'(col_max[col]) - longint'(col_min[col]);
            if (den == 0)
                res.status = ST_ZERO;
            else
                r = longint'(range_low)
                    + ((longint'(range_high) - longint'(range_low))
                       * (x - longint'(col_min[col]))) / den;
        end
        if (r > 64'sd2147483647)
        begin
            r          = 64'sd2147483647;
            res.status = ST_SAT;
        end
        else if (r < -64'sd2147483648)
        begin
            r          = -64'sd2147483648;
            res.status = ST_SAT;
        end
        res.value = r[31:0];
        scaled_q.push_back(res);
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Send one element; leave valid high so a back-to-back element needs no drop
    task automatic send_element(req_t req, logic [11:0] col, logic first,
                                logic signed [23:0] sample);
        bit taken;
        int gap;
        in_if.valid     <= 1'b1;
        in_if.req_type  <= req;
        in_if.col_index <= col;
        in_if.first_row <= first;
        in_if.sample    <= sample;
        do
        begin
            @(negedge clk);
            taken = in_if.ready;
            @(posedge clk);
        end
        while (!taken);
        predict_scaling(req, col, first, sample);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait for every result, then for the gather latency
    task automatic drain_block();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (scaled_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_range(cfg_idx_t idx, logic signed [31:0] data);
        bit taken;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do
        begin
            @(negedge clk);
            taken = cfg_if.ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_RANGE_LOW)
            range_low = data;
        else
            range_high = data;
        @(posedge clk);
    endtask

    task automatic set_range(logic signed [31:0] lo, logic signed [31:0] hi);
        drain_block();
        write_range(CFG_RANGE_LOW, lo);
        write_range(CFG_RANGE_HIGH, hi);
    endtask

    // Receiver: random stalls, plus a long hold-off when requested
    initial begin
        int stall;
        out_if.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                out_if.ready <= 1'b0;
                hold_off--;
            end
            else if (no_idle)
                out_if.ready <= 1'b1;
            else if (stall > 0)
            begin
                out_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_if.ready <= 1'b1;
                if ($urandom_range(99) < 35)
                    stall = ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                                     : $urandom_range(3, 1);
            end
        end
    end

    // Result checker: a transaction completes at the edge after a negedge
    // that sees valid and ready both high
    always @(negedge clk)
    begin
        scaled_t exp_res;
        if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        begin
            if (scaled_q.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d status=%0d", $time,
                         out_if.scaled_value, out_if.status);
                error_count++;
            end
            else
            begin
                exp_res = scaled_q.pop_front();
                if (out_if.scaled_value !== exp_res.value)
                begin
                    $display("%0t: scaled_value expected %0d actual %0d", $time,
                             exp_res.value, out_if.scaled_value);
                    error_count++;
                end
                if (out_if.status !== exp_res.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_res.status, out_if.status);
                    error_count++;
                end
            end
        end
    end

    // Draw a sample: full range, narrow band around a centre, or an extreme
    function automatic logic signed [23:0] pick_sample(logic signed [23:0] centre);
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return 24'($urandom());
        if (roll < 85)
            return centre + $signed(24'($urandom_range(200))) - 24'sd100;
        if (roll < 92)
            return 24'sh800000;
        return 24'sh7fffff;
    endfunction

    // L2 mode at reset: extremes, a zero-norm column, a saturating column
    task automatic test_l2_directed();
        send_element(REQ_GATHER, 12'd4095, 1'b1, 24'sh800000);
        send_element(REQ_GATHER, 12'd4095, 1'b0, 24'sh7fffff);
        send_element(REQ_GATHER, 12'd0, 1'b1, 24'sd0);
        send_element(REQ_GATHER, 12'd0, 1'b0, 24'sd0);
        send_element(REQ_GATHER, 12'd1, 1'b1, 24'sd1);
        send_element(REQ_APPLY, 12'd4095, 1'b0, 24'sh800000);
        send_element(REQ_APPLY, 12'd4095, 1'b1, 24'sh7fffff);
        send_element(REQ_APPLY, 12'd0, 1'b0, 24'sd5);
        send_element(REQ_APPLY, 12'd1, 1'b0, 24'sh7fffff);
        send_element(REQ_APPLY, 12'd1, 1'b0, 24'sh800000);
        send_element(REQ_APPLY, 12'd1, 1'b0, -24'sd3);
    endtask

    // Min-max mode: zero span, out-of-column saturation, inverted range
    task automatic test_minmax_directed();
        set_range(32'sh80000000, 32'sh7fffffff);
        send_element(REQ_GATHER, 12'd2, 1'b1, 24'sd7);
        send_element(REQ_GATHER, 12'd2, 1'b0, 24'sd7);
        send_element(REQ_GATHER, 12'd3, 1'b1, -24'sd10);
        send_element(REQ_GATHER, 12'd3, 1'b0, 24'sd10);
        send_element(REQ_APPLY, 12'd2, 1'b0, 24'sd7);
        send_element(REQ_APPLY, 12'd3, 1'b0, 24'sd0);
        send_element(REQ_APPLY, 12'd3, 1'b0, 24'sh7fffff);
        send_element(REQ_APPLY, 12'd3, 1'b0, 24'sh800000);
        set_range(32'sh7fffffff, 32'sh80000000);
        send_element(REQ_APPLY, 12'd3, 1'b0, 24'sd3);
        send_element(REQ_APPLY, 12'd4095, 1'b0, 24'sd0);
    endtask

    // Hold the receiver off while apply elements keep coming
    task automatic test_output_pressure();
        set_range(Q16_MONE, Q16_ONE);
        hold_off = 600;
        repeat (12)
            send_element(REQ_APPLY, 12'd4095, 1'b0, pick_sample(24'sd0));
    endtask

    // Random matrices, gathered then applied, with range changes between them
    task automatic test_random_matrices();
        logic signed [31:0] lows  [6] = '{Q16_MONE, 32'sd0, 32'sh80000000,
                                          32'sh7fffffff, Q16_MONE, 32'sd12345};
        logic signed [31:0] highs [6] = '{Q16_ONE, 32'sd65536, 32'sh7fffffff,
                                          32'sh80000000, 32'sd65535, 32'sd12345};
        logic signed [23:0] centre;
        int                 ncols;
        int                 nrows;
        int                 base;
        int                 setting;
        int                 matrix;
        matrix = 0;
        while (items_sent < 1800)
        begin
            if (matrix % 4 == 0)
            begin
                setting = $urandom_range(5);
                no_idle = 1'b0;
                set_range(lows[setting], highs[setting]);
                no_idle = ($urandom_range(4) == 0);
            end
            matrix++;
            ncols  = $urandom_range(6, 1);
            nrows  = $urandom_range(8, 1);
            base   = $urandom_range(4096 - ncols);
            centre = 24'($urandom());
            for (int r = 0; r < nrows; r++)
                for (int c = 0; c < ncols; c++)
                    send_element(REQ_GATHER, 12'(base + c), r == 0,
                                 ($urandom_range(9) == 0) ? centre : pick_sample(centre));
            for (int r = 0; r < nrows; r++)
                for (int c = 0; c < ncols; c++)
                    send_element(REQ_APPLY, 12'(base + c), 1'($urandom_range(1)),
                                 pick_sample(centre));
            // Noise: stray seeds and applies outside the column's own range
            if ($urandom_range(2) == 0)
                send_element(REQ_GATHER, 12'($urandom()), 1'b1, 24'($urandom()));
            if ($urandom_range(2) == 0)
                send_element(REQ_APPLY, 12'(base), 1'b0, 24'($urandom()));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        error_count     = 0;
        items_sent      = 0;
        hold_off        = 0;
        no_idle         = 1'b0;
        range_low       = Q16_MONE;
        range_high      = Q16_ONE;
        rst_n           = 1'b0;
        in_if.valid     = 1'b0;
        in_if.req_type  = REQ_GATHER;
        in_if.col_index = '0;
        in_if.first_row = 1'b0;
        in_if.sample    = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = CFG_RANGE_LOW;
        cfg_if.data     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_l2_directed();
        test_minmax_directed();
        test_output_pressure();
        test_random_matrices();
        set_range(Q16_MONE, Q16_ONE);
        repeat (100) @(posedge clk);

        if (error_count == 0)
            $display("[column_normalize_two_pass] OK");
        else
            $display("[column_normalize_two_pass] ERROR");
        $finish;
    end
endmodule
